### sv/grb_pkg.sv
// Shared constants, types and helpers for the glyph run rectangle block.
package grb_pkg;

  // Glyph geometry and field widths
  localparam int GLYPH_EDGE = 8;
  localparam int BYTE_W     = 8;
  localparam int IDX_W      = $clog2(BYTE_W);
  localparam int COORD_W    = 11;
  localparam int SCALE_W    = 4;
  localparam int COL_W      = 5;
  localparam int ROW_W      = 6;
  localparam int LEN_W      = 6;
  localparam int RW_W       = 9;
  localparam int CFG_IDX_W  = 1;

  localparam logic [BYTE_W-1:0]  FIRST_BIT_MASK = 8'h80;
  localparam logic [COORD_W-1:0] COORD_MAX      = 11'h7FF;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SCALE_X = 1'b0,
    CFG_SCALE_Y = 1'b1
  } cfg_reg_t;

  // One closed run of set pixels
  typedef struct packed {
    logic [COL_W-1:0] start;
    logic [LEN_W-1:0] len;
    logic [ROW_W-1:0] row;
  } run_t;

  // All runs closed by one byte, one slot per bit position
  typedef struct packed {
    logic [BYTE_W-1:0]       vld;
    run_t [BYTE_W-1:0]       runs;
  } run_set_t;

  // A zero scale counts as one
  function automatic logic [SCALE_W-1:0] eff_scale(input logic [SCALE_W-1:0] s);
    eff_scale = (s == '0) ? SCALE_W'(1) : s;
  endfunction

endpackage

### sv/glyph_bitmap_run_rectangles.sv
// A byte's first rectangle passes the input register, run buffer and output register.
// Throughput: one rectangle per cycle while out_stall is low; a byte holds the run buffer
// until its last run is emitted, and the rate is set by the single output register.
// A new byte is taken while the previous byte's rectangles are still going out.
// Reset (synchronous, rst_n low): handshakes idle, scales 1, glyph position and origin 0.
module glyph_bitmap_run_rectangles (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [grb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [grb_pkg::SCALE_W-1:0]   cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_glyph_start,
  input  logic [grb_pkg::COORD_W-1:0]   in_origin_x,
  input  logic [grb_pkg::COORD_W-1:0]   in_origin_y,
  input  logic [grb_pkg::BYTE_W-1:0]    in_bits,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [grb_pkg::COORD_W-1:0]   out_rect_x,
  output logic [grb_pkg::COORD_W-1:0]   out_rect_y,
  output logic [grb_pkg::RW_W-1:0]      out_rect_w,
  output logic [grb_pkg::SCALE_W-1:0]   out_rect_h,
  output logic                          out_last
);
  import grb_pkg::*;

  logic [SCALE_W-1:0]  scale_x_r, scale_y_r;
  logic                buf_free, load_vld, runs_pend;
  run_set_t            run_set;
  logic [COORD_W-1:0]  held_x, held_y;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_x_r <= SCALE_W'(1);
      scale_y_r <= SCALE_W'(1);
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        CFG_SCALE_X: scale_x_r <= cfg_data;
        CFG_SCALE_Y: scale_y_r <= cfg_data;
        default: ;
      endcase
    end
  end

  grb_scan u_scan (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_glyph_start (in_glyph_start),
    .in_origin_x    (in_origin_x),
    .in_origin_y    (in_origin_y),
    .in_bits        (in_bits),
    .buf_free       (buf_free),
    .load_vld       (load_vld),
    .run_set        (run_set),
    .held_x         (held_x),
    .held_y         (held_y)
  );

  grb_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .load_vld   (load_vld),
    .run_set    (run_set),
    .held_x     (held_x),
    .held_y     (held_y),
    .scale_x    (scale_x_r),
    .scale_y    (scale_y_r),
    .buf_free   (buf_free),
    .runs_pend  (runs_pend),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_rect_x (out_rect_x),
    .out_rect_y (out_rect_y),
    .out_rect_w (out_rect_w),
    .out_rect_h (out_rect_h),
    .out_last   (out_last)
  );

  // A non-final rectangle always leaves more runs of its byte in the buffer
  a_more_after_nonlast: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> runs_pend)
    else $error("non-final rectangle with empty run buffer");

  // The input side only stalls behind a busy run buffer
  a_stall_needs_pend: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> runs_pend)
    else $error("input stalled with no runs pending");

  // Every emitted rectangle has nonzero width
  a_width_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_rect_w != '0)
    else $error("zero-width rectangle emitted");

endmodule

### sv/grb_scan.sv
// Input register and row scan: turns one glyph byte into a set of closed runs.
module grb_scan (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_glyph_start,
  input  logic [grb_pkg::COORD_W-1:0]   in_origin_x,
  input  logic [grb_pkg::COORD_W-1:0]   in_origin_y,
  input  logic [grb_pkg::BYTE_W-1:0]    in_bits,
  input  logic                          buf_free,
  output logic                          load_vld,
  output grb_pkg::run_set_t             run_set,
  output logic [grb_pkg::COORD_W-1:0]   held_x,
  output logic [grb_pkg::COORD_W-1:0]   held_y
);
  import grb_pkg::*;

  logic                 in_vld_r, in_vld_nxt;
  logic                 in_start_r;
  logic [COORD_W-1:0]   in_ox_r, in_oy_r;
  logic [BYTE_W-1:0]    in_bits_r;
  logic                 accept;

  logic [COL_W-1:0]     col_r, col_nxt;
  logic [ROW_W-1:0]     row_r, row_nxt;
  logic [LEN_W-1:0]     rl_r, rl_nxt;
  logic [COORD_W-1:0]   hox_r, hox_nxt, hoy_r, hoy_nxt;

  logic [COL_W:0]       col_v;
  logic [ROW_W-1:0]     rw_v;
  logic [LEN_W-1:0]     rl_v;

  // Hand the held byte over once the run buffer can take it
  assign load_vld = in_vld_r && buf_free;
  assign in_stall = in_vld_r && !buf_free;
  assign accept   = in_valid && !in_stall;
  assign held_x   = hox_r;
  assign held_y   = hoy_r;

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (accept) begin
      in_vld_nxt = 1'b1;
    end else if (load_vld) begin
      in_vld_nxt = 1'b0;
    end
  end

  // Walk the eight pixels of the byte, closing runs on clear pixels and row ends
  always_comb begin
    col_v   = in_start_r ? '0 : {1'b0, col_r};
    rw_v    = in_start_r ? '0 : row_r;
    rl_v    = in_start_r ? '0 : rl_r;
    hox_nxt = in_start_r ? in_ox_r : hox_r;
    hoy_nxt = in_start_r ? in_oy_r : hoy_r;
    run_set = '0;
    for (int i = 0; i < BYTE_W; i++) begin
      if (rw_v < ROW_W'(GLYPH_EDGE)) begin
        if ((in_bits_r & (FIRST_BIT_MASK >> i)) != '0) begin
          rl_v = rl_v + LEN_W'(1);
        end else if (rl_v != '0) begin
          run_set.vld[i]        = 1'b1;
          run_set.runs[i].start = COL_W'(col_v - (COL_W+1)'(rl_v));
          run_set.runs[i].len   = rl_v;
          run_set.runs[i].row   = rw_v;
          rl_v                  = '0;
        end
        col_v = col_v + (COL_W+1)'(1);
        if (col_v >= (COL_W+1)'(GLYPH_EDGE)) begin
          if (rl_v != '0) begin
            run_set.vld[i]        = 1'b1;
            run_set.runs[i].start = COL_W'((COL_W+1)'(GLYPH_EDGE) - (COL_W+1)'(rl_v));
            run_set.runs[i].len   = rl_v;
            run_set.runs[i].row   = rw_v;
          end
          rl_v  = '0;
          col_v = '0;
          rw_v  = rw_v + ROW_W'(1);
        end
      end
    end
    col_nxt = COL_W'(col_v);
    row_nxt = rw_v;
    rl_nxt  = rl_v;
  end

  // Input stage control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= in_vld_nxt;
    end
  end

  // Input stage payload
  always_ff @(posedge clk) begin
    if (accept) begin
      in_start_r <= in_glyph_start;
      in_ox_r    <= in_origin_x;
      in_oy_r    <= in_origin_y;
      in_bits_r  <= in_bits;
    end
  end

  // Advance glyph position on each handed-over byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
      rl_r  <= '0;
      hox_r <= '0;
      hoy_r <= '0;
    end else if (load_vld) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      rl_r  <= rl_nxt;
      hox_r <= hox_nxt;
      hoy_r <= hoy_nxt;
    end
  end

endmodule

### sv/grb_emit.sv
// Run buffer and rectangle output register: scales one run per cycle while the output is not stalled.
module grb_emit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          load_vld,
  input  grb_pkg::run_set_t             run_set,
  input  logic [grb_pkg::COORD_W-1:0]   held_x,
  input  logic [grb_pkg::COORD_W-1:0]   held_y,
  input  logic [grb_pkg::SCALE_W-1:0]   scale_x,
  input  logic [grb_pkg::SCALE_W-1:0]   scale_y,
  output logic                          buf_free,
  output logic                          runs_pend,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [grb_pkg::COORD_W-1:0]   out_rect_x,
  output logic [grb_pkg::COORD_W-1:0]   out_rect_y,
  output logic [grb_pkg::RW_W-1:0]      out_rect_w,
  output logic [grb_pkg::SCALE_W-1:0]   out_rect_h,
  output logic                          out_last
);
  import grb_pkg::*;

  logic [BYTE_W-1:0]          pend_r, pend_nxt;
  run_t [BYTE_W-1:0]          runs_r;
  logic [IDX_W-1:0]           sel_idx;
  logic [BYTE_W-1:0]          rest;
  run_t                       cur;
  logic                       out_adv, emit_now;

  logic [SCALE_W-1:0]         sx, sy;
  logic [COL_W+SCALE_W-1:0]   px;
  logic [ROW_W+SCALE_W-1:0]   py;
  logic [LEN_W+SCALE_W-1:0]   pw;
  logic [COORD_W:0]           sum_x, sum_y;

  logic                       out_vld_r;
  logic [COORD_W-1:0]         out_x_r, out_y_r;
  logic [RW_W-1:0]            out_w_r;
  logic [SCALE_W-1:0]         out_h_r;
  logic                       out_last_r;

  // Pick the lowest pending run
  always_comb begin
    sel_idx = '0;
    for (int i = BYTE_W - 1; i >= 0; i--) begin
      if (pend_r[i]) begin
        sel_idx = IDX_W'(i);
      end
    end
  end

  assign rest      = pend_r & ~(BYTE_W'(1) << sel_idx);
  assign cur       = runs_r[sel_idx];
  assign runs_pend = |pend_r;
  assign out_adv   = !out_vld_r || !out_stall;
  assign emit_now  = runs_pend && out_adv;
  assign buf_free  = !runs_pend || (emit_now && (rest == '0));

  // Scale and place the selected run, saturating coordinates
  always_comb begin
    sx    = eff_scale(scale_x);
    sy    = eff_scale(scale_y);
    px    = (COL_W+SCALE_W)'(cur.start) * (COL_W+SCALE_W)'(sx);
    py    = (ROW_W+SCALE_W)'(cur.row) * (ROW_W+SCALE_W)'(sy);
    pw    = (LEN_W+SCALE_W)'(cur.len) * (LEN_W+SCALE_W)'(sx);
    sum_x = (COORD_W+1)'(held_x) + (COORD_W+1)'(px);
    sum_y = (COORD_W+1)'(held_y) + (COORD_W+1)'(py);
  end

  // Load a fresh run set or drop the one just emitted
  always_comb begin
    pend_nxt = pend_r;
    if (load_vld) begin
      pend_nxt = run_set.vld;
    end else if (emit_now) begin
      pend_nxt = rest;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r    <= '0;
      out_vld_r <= 1'b0;
    end else begin
      pend_r <= pend_nxt;
      if (out_adv) begin
        out_vld_r <= emit_now;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_vld) begin
      runs_r <= run_set.runs;
    end
  end

  // Hold the result beat until taken
  always_ff @(posedge clk) begin
    if (emit_now) begin
      out_x_r    <= sum_x[COORD_W] ? COORD_MAX : sum_x[COORD_W-1:0];
      out_y_r    <= sum_y[COORD_W] ? COORD_MAX : sum_y[COORD_W-1:0];
      out_w_r    <= pw[RW_W-1:0];
      out_h_r    <= sy;
      out_last_r <= (rest == '0);
    end
  end

  assign out_valid  = out_vld_r;
  assign out_rect_x = out_x_r;
  assign out_rect_y = out_y_r;
  assign out_rect_w = out_w_r;
  assign out_rect_h = out_h_r;
  assign out_last   = out_last_r;

endmodule
